### rtl/core/c3f_pkg.sv
// shared constants, types and register codes for the 3x3 convolution filter
package c3f_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int KERNEL_SIZE    = 3;
    localparam int KERNEL_TAPS    = KERNEL_SIZE * KERNEL_SIZE;
    localparam int COEF_FRAC_BITS = 8;
    localparam int COEF_W         = 16;
    localparam int PIX_W          = 8;
    localparam int ROW_W          = 16;
    localparam int COL_OUT_W      = 10;
    localparam int CFG_W          = 48;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_WIDTH_W    = 11;
    localparam int MIN_DIM        = 3;
    localparam int WIDTH_RST      = 1024;
    localparam int PROD_W         = COEF_W + PIX_W + 1;
    localparam int RSUM_W         = PROD_W + 2;
    localparam int SUM_W          = RSUM_W + 2;

    localparam logic [PIX_W-1:0] PIX_MAX        = 8'd255;
    localparam logic [ROW_W-1:0] HEIGHT_RST     = 16'd768;
    localparam logic [CFG_W-1:0] KERNEL_TOP_RST = 48'h0000_0000_0000;
    localparam logic [CFG_W-1:0] KERNEL_MID_RST = 48'h0000_0100_0000;
    localparam logic [CFG_W-1:0] KERNEL_BOT_RST = 48'h0000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_K_TOP  = 3'd2,
        CFG_K_MID  = 3'd3,
        CFG_K_BOT  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0]     filtered_pixel;
        logic [ROW_W-1:0]     pixel_row;
        logic [COL_OUT_W-1:0] pixel_col;
        logic                 last_of_frame;
    } t_out_item;

    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
        logic                 last;
    } t_meta;

    typedef logic [KERNEL_TAPS-1:0][PIX_W-1:0] t_window;
    typedef logic [KERNEL_SIZE-1:0][CFG_W-1:0] t_kernel;

endpackage

### rtl/core/c3f_ram.sv
// generic single-port-write, registered-read memory (read-first)
module c3f_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/c3f_front.sv
// position counters, line buffer memory with forwarding, and the 3x3 window
module c3f_front import c3f_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int WID_W = COL_W + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    input  logic [WID_W-1:0] i_width,
    input  logic [ROW_W-1:0] i_height,
    output logic             o_win_valid,
    input  logic             i_win_ready,
    output t_window          o_win,
    output t_meta            o_meta
);

    localparam int LB_W = 2 * PIX_W;

    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;

    logic             r_v1;
    logic [PIX_W-1:0] r_pix1;
    logic [COL_W-1:0] r_addr1;
    logic             r_emit1;
    t_meta            r_meta1;
    logic             r_fwd;
    logic [LB_W-1:0]  r_fwd_data;

    logic             r_v2;
    t_window          r_win;
    t_meta            r_meta2;

    logic             accept;
    logic             s2_free;
    logic             s1_adv;
    logic [ROW_W-1:0] cur_row;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W:0]   row_inc;
    logic [WID_W-1:0] col_inc;
    logic             col_wrap;
    logic             row_wrap;
    logic             emit;
    logic             last;
    logic [ROW_W-1:0] row_m1;
    logic [COL_W-1:0] col_m1;
    logic [COL_OUT_W-1:0] col_out;
    t_meta            n_meta;

    logic [LB_W-1:0]  ram_rdata;
    logic [LB_W-1:0]  lb_data;
    logic [LB_W-1:0]  wdata;

    assign s2_free    = !r_v2 || i_win_ready;
    assign s1_adv     = r_v1 && s2_free;
    assign o_in_ready = !r_v1 || s2_free;
    assign accept     = i_in_valid && o_in_ready;

    assign cur_row  = i_in_data.frame_start ? '0 : r_row;
    assign cur_col  = i_in_data.frame_start ? '0 : r_col;
    assign row_inc  = {1'b0, cur_row} + 1'b1;
    assign col_inc  = {1'b0, cur_col} + 1'b1;
    assign col_wrap = col_inc >= i_width;
    assign row_wrap = row_inc >= {1'b0, i_height};
    assign emit     = (cur_row > ROW_W'(1)) && (cur_col > COL_W'(1));
    assign last     = (row_inc == {1'b0, i_height}) && (col_inc == i_width);
    assign row_m1   = cur_row - 1'b1;
    assign col_m1   = cur_col - 1'b1;

    generate
        if (COL_W >= COL_OUT_W) begin : g_col_trunc
            assign col_out = col_m1[COL_OUT_W-1:0];
        end else begin : g_col_ext
            assign col_out = {{(COL_OUT_W-COL_W){1'b0}}, col_m1};
        end
    endgenerate

    assign n_meta = '{row: row_m1, col: col_out, last: last};

    // upper row in the high byte, lower row in the low byte
    assign lb_data = r_fwd ? r_fwd_data : ram_rdata;
    assign wdata   = {lb_data[PIX_W-1:0], r_pix1};

    c3f_ram #(
        .DATA_W (LB_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_addr1),
        .i_wdata (wdata),
        .i_re    (accept),
        .i_raddr (cur_col),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            if (accept) begin
                if (col_wrap) begin
                    r_col <= '0;
                    r_row <= row_wrap ? '0 : row_inc[ROW_W-1:0];
                end else begin
                    r_col <= col_inc[COL_W-1:0];
                    r_row <= cur_row;
                end
            end
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (s1_adv) begin
                r_v1 <= 1'b0;
            end
            if (s1_adv) begin
                r_v2 <= r_emit1;
            end else if (i_win_ready) begin
                r_v2 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix1     <= i_in_data.pixel;
            r_addr1    <= cur_col;
            r_emit1    <= emit;
            r_meta1    <= n_meta;
            r_fwd      <= s1_adv && (r_addr1 == cur_col);
            r_fwd_data <= wdata;
        end
        if (s1_adv) begin
            for (int i = 0; i < KERNEL_SIZE; i++) begin
                r_win[i*KERNEL_SIZE + 0] <= r_win[i*KERNEL_SIZE + 1];
                r_win[i*KERNEL_SIZE + 1] <= r_win[i*KERNEL_SIZE + 2];
            end
            r_win[2] <= lb_data[LB_W-1:PIX_W];
            r_win[5] <= lb_data[PIX_W-1:0];
            r_win[8] <= r_pix1;
            r_meta2  <= r_meta1;
        end
    end

    assign o_win_valid = r_v2;
    assign o_win       = r_win;
    assign o_meta      = r_meta2;

endmodule

### rtl/core/c3f_mac.sv
// multiply, row sums, total with floor and clamp, output register
module c3f_mac import c3f_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_win_valid,
    output logic      o_win_ready,
    input  t_window   i_win,
    input  t_meta     i_meta,
    input  t_kernel   i_kernel,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic                     r_v3;
    logic signed [PROD_W-1:0] r_prod [KERNEL_TAPS];
    t_meta                    r_meta3;

    logic                     r_v4;
    logic signed [RSUM_W-1:0] r_rsum [KERNEL_SIZE];
    t_meta                    r_meta4;

    logic                     r_out_v;
    t_out_item                r_out;

    logic                     out_free;
    logic                     s4_free;
    logic                     s3_free;
    logic signed [PROD_W-1:0] n_prod [KERNEL_TAPS];
    logic signed [RSUM_W-1:0] n_rsum [KERNEL_SIZE];
    logic signed [SUM_W-1:0]  total;
    logic [SUM_W-2:0]         shifted;
    logic [PIX_W-1:0]         n_pix;

    assign out_free    = !r_out_v || i_out_ready;
    assign s4_free     = !r_v4 || out_free;
    assign s3_free     = !r_v3 || s4_free;
    assign o_win_ready = s3_free;

    always_comb begin
        for (int i = 0; i < KERNEL_SIZE; i++) begin
            for (int j = 0; j < KERNEL_SIZE; j++) begin
                n_prod[i*KERNEL_SIZE + j] =
                    $signed(i_kernel[i][COEF_W*j +: COEF_W]) *
                    $signed({1'b0, i_win[i*KERNEL_SIZE + j]});
            end
        end
    end

    always_comb begin
        for (int i = 0; i < KERNEL_SIZE; i++) begin
            n_rsum[i] = RSUM_W'(r_prod[i*KERNEL_SIZE + 0])
                      + RSUM_W'(r_prod[i*KERNEL_SIZE + 1])
                      + RSUM_W'(r_prod[i*KERNEL_SIZE + 2]);
        end
    end

    // negative sums give zero, positive ones floor then saturate
    always_comb begin
        total   = SUM_W'(r_rsum[0]) + SUM_W'(r_rsum[1]) + SUM_W'(r_rsum[2]);
        shifted = total[SUM_W-2:0] >> COEF_FRAC_BITS;
        if (total[SUM_W-1]) begin
            n_pix = '0;
        end else if (shifted > (SUM_W-1)'(PIX_MAX)) begin
            n_pix = PIX_MAX;
        end else begin
            n_pix = shifted[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s3_free) begin
                r_v3 <= i_win_valid;
            end
            if (s4_free) begin
                r_v4 <= r_v3;
            end
            if (out_free) begin
                r_out_v <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_free) begin
            r_prod  <= n_prod;
            r_meta3 <= i_meta;
        end
        if (s4_free) begin
            r_rsum  <= n_rsum;
            r_meta4 <= r_meta3;
        end
        if (out_free && r_v4) begin
            r_out <= '{filtered_pixel: n_pix,
                       pixel_row:      r_meta4.row,
                       pixel_col:      r_meta4.col,
                       last_of_frame:  r_meta4.last};
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

### rtl/core/conv3x3_image_filter.sv
// top level of the streaming 3x3 convolution filter with its register file
//
// usage
//   input channel: one 8-bit grayscale pixel per request in raster order,
//   frame_start set on the first pixel of a frame restarts row and column.
//   output channel: one request per interior pixel (row and column both
//   at least 1 and below the last), with its row, column and a flag on the
//   last interior pixel of the frame. border pixels produce no request.
//   config port: write enable, register index, 48-bit data, taken at once;
//   index 0 width, 1 height, 2..4 kernel rows (three signed q8.8 each).
//   throughput: one pixel per cycle unless the output stalls, limited by
//   the line buffer memory which is read once and written once per pixel.
//   path: an accepted pixel that completes a window passes the memory read,
//   window, products, row sums and total registers to give its result.
//   reset: counters clear, registers return to width 1024, height 768 and
//   the identity kernel; line buffer contents are not cleared and need no
//   clearing pass, since the first two rows of a frame give no output.
//   stall: a waiting result sits in the output register; pixels keep being
//   accepted until every pipeline stage behind it holds a result.
module conv3x3_image_filter import c3f_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WID_W       = COL_W + 1;
    localparam int WIDTH_RST_C = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

    logic [WID_W-1:0] r_width;
    logic [ROW_W-1:0] r_height;
    t_kernel          r_kernel;

    logic [CFG_WIDTH_W-1:0] cfg_w;
    logic [ROW_W-1:0]       cfg_h;
    logic [WID_W-1:0]       n_width;
    logic [ROW_W-1:0]       n_height;

    logic    win_valid;
    logic    win_ready;
    t_window win;
    t_meta   win_meta;

    assign cfg_w = i_cfg_data[CFG_WIDTH_W-1:0];
    assign cfg_h = i_cfg_data[ROW_W-1:0];

    // widths and heights are stored already clamped to their usable range
    always_comb begin
        if (int'(cfg_w) < MIN_DIM) begin
            n_width = WID_W'(MIN_DIM);
        end else if (int'(cfg_w) > MAX_WIDTH) begin
            n_width = WID_W'(MAX_WIDTH);
        end else begin
            n_width = WID_W'(cfg_w);
        end
        if (int'(cfg_h) < MIN_DIM) begin
            n_height = ROW_W'(MIN_DIM);
        end else begin
            n_height = cfg_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WID_W'(WIDTH_RST_C);
            r_height    <= HEIGHT_RST;
            r_kernel[0] <= KERNEL_TOP_RST;
            r_kernel[1] <= KERNEL_MID_RST;
            r_kernel[2] <= KERNEL_BOT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_width     <= n_width;
                CFG_HEIGHT: r_height    <= n_height;
                CFG_K_TOP:  r_kernel[0] <= i_cfg_data;
                CFG_K_MID:  r_kernel[1] <= i_cfg_data;
                CFG_K_BOT:  r_kernel[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    c3f_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_width     (r_width),
        .i_height    (r_height),
        .o_win_valid (win_valid),
        .i_win_ready (win_ready),
        .o_win       (win),
        .o_meta      (win_meta)
    );

    c3f_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_win_valid (win_valid),
        .o_win_ready (win_ready),
        .i_win       (win),
        .i_meta      (win_meta),
        .i_kernel    (r_kernel),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### rtl/core/c3f_checker.sv
// port-level checks for the convolution filter, bound to the top level
module c3f_checker import c3f_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result request dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // results for row 0 or column 0 never show up
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.pixel_row != '0) && (o_out_data.pixel_col != '0))
        else $error("border pixel emitted");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result request right after reset");

endmodule

bind conv3x3_image_filter c3f_checker u_c3f_checker (.*);

### tb/tb.sv
// self-checking testbench for the streaming 3x3 convolution filter
`timescale 1ns / 100ps

module tb import c3f_pkg::*; ();

    localparam int RAND_ITEMS   = 950;
    localparam int QUIET_TAIL   = 150;
    localparam int FRAME_CAP    = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int BIG_WIDTH    = 2047;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
        logic             typed;
        t_out_item        want;
    } t_step;

    // identity kernel: the 9th pixel of a 3x3 frame returns the center pixel
    localparam t_step DIR_STEPS [22] = '{
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hA5, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, '{8'hA5, 16'd1, 10'd1, 1'b1}},
        // frame wraps without frame_start, then a frame_start mid-frame
        '{8'h12, 1'b0, 1'b0, '0},
        '{8'h34, 1'b0, 1'b0, '0},
        '{8'h56, 1'b0, 1'b0, '0},
        '{8'h78, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b1, '{8'h00, 16'd1, 10'd1, 1'b1}}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b1;
    t_out_item            o_out_data;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    conv3x3_image_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // filter state mirrored from the block
    logic [CFG_WIDTH_W-1:0] cfg_width;
    logic [ROW_W-1:0]       cfg_height;
    logic [CFG_W-1:0]       kern [KERNEL_SIZE];
    logic [PIX_W-1:0]       line_top [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]       line_mid [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]       win [KERNEL_TAPS];
    int unsigned            row_at;
    int unsigned            col_at;

    t_out_item filtered_due [$];
    t_out_item want;
    bit        idle_on = 1'b0;
    int        stall_left = 0;
    int        errors = 0;

    function automatic int unsigned eff_cols();
        if (cfg_width < MIN_DIM) return MIN_DIM;
        if (cfg_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_rows();
        if (cfg_height < MIN_DIM) return MIN_DIM;
        return cfg_height;
    endfunction

    function automatic bit convolve_pixel(input t_in_item px, output t_out_item res);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        longint      acc;
        bit          unknown;
        w = eff_cols();
        h = eff_rows();
        res = '0;
        if (px.frame_start) begin
            row_at = 0;
            col_at = 0;
        end
        r = row_at;
        c = col_at;
        for (int i = 0; i < KERNEL_SIZE; i++) begin
            win[KERNEL_SIZE*i]     = win[KERNEL_SIZE*i + 1];
            win[KERNEL_SIZE*i + 1] = win[KERNEL_SIZE*i + 2];
        end
        win[2] = line_top[c];
        win[5] = line_mid[c];
        win[8] = px.pixel;
        line_top[c] = line_mid[c];
        line_mid[c] = px.pixel;
        if (c + 1 >= w) begin
            col_at = 0;
            row_at = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_at = c + 1;
        end
        if (r < 2 || c < 2) return 1'b0;
        // line buffer entries never written give no defined value
        unknown = 1'b0;
        for (int k = 0; k < KERNEL_TAPS; k++) begin
            unknown |= $isunknown(win[k]);
        end
        acc = 0;
        for (int i = 0; i < KERNEL_SIZE; i++) begin
            for (int j = 0; j < KERNEL_SIZE; j++) begin
                acc += longint'($signed(kern[i][COEF_W*j +: COEF_W]))
                       * longint'(win[KERNEL_SIZE*i + j]);
            end
        end
        if (unknown) begin
            res.filtered_pixel = 'x;
        end else if (acc < 0) begin
            res.filtered_pixel = '0;
        end else if ((acc >>> COEF_FRAC_BITS) > longint'(PIX_MAX)) begin
            res.filtered_pixel = PIX_MAX;
        end else begin
            res.filtered_pixel = PIX_W'(acc >>> COEF_FRAC_BITS);
        end
        res.pixel_row     = ROW_W'(r - 1);
        res.pixel_col     = COL_OUT_W'(c - 1);
        res.last_of_frame = (r + 1 == h) && (c + 1 == w);
        return 1'b1;
    endfunction

    function automatic logic [CFG_W-1:0] rnd48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [CFG_W-1:0] kernel_row_mix();
        logic [CFG_W-1:0] row;
        int unsigned      style;
        style = $urandom_range(0, 7);
        for (int j = 0; j < KERNEL_SIZE; j++) begin
            case (style)
                0: row[COEF_W*j +: COEF_W] = 16'($urandom);
                1: row[COEF_W*j +: COEF_W] = 16'h7FFF;
                2: row[COEF_W*j +: COEF_W] = 16'h8000;
                3: row[COEF_W*j +: COEF_W] = '0;
                default: row[COEF_W*j +: COEF_W] = 16'($urandom_range(0, 200)) - 16'd60;
            endcase
        end
        return row;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_WIDTH:  cfg_width  = val[CFG_WIDTH_W-1:0];
            CFG_HEIGHT: cfg_height = val[ROW_W-1:0];
            CFG_K_TOP:  kern[0]    = val;
            CFG_K_MID:  kern[1]    = val;
            CFG_K_BOT:  kern[2]    = val;
            default: ;
        endcase
    endtask

    task automatic push_pixel(input t_in_item px, input bit typed, input t_out_item typed_res);
        t_out_item res;
        bit        hit;
        hit = convolve_pixel(px, res);
        if (typed) begin
            filtered_due.push_back(typed_res);
        end else if (hit) begin
            filtered_due.push_back(res);
        end
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic flush_pipe();
        i_in_valid <= 1'b0;
        while (filtered_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= (stall_left == 1);
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(1, 15);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (filtered_due.size() == 0) begin
                $error("unexpected result: row %0d col %0d value %0d",
                       o_out_data.pixel_row, o_out_data.pixel_col,
                       o_out_data.filtered_pixel);
                errors++;
            end else begin
                want = filtered_due.pop_front();
                if (!$isunknown(want.filtered_pixel) &&
                    o_out_data.filtered_pixel !== want.filtered_pixel) begin
                    $error("filtered_pixel: expected %0d, got %0d",
                           want.filtered_pixel, o_out_data.filtered_pixel);
                    errors++;
                end
                if (o_out_data.pixel_row !== want.pixel_row) begin
                    $error("pixel_row: expected %0d, got %0d",
                           want.pixel_row, o_out_data.pixel_row);
                    errors++;
                end
                if (o_out_data.pixel_col !== want.pixel_col) begin
                    $error("pixel_col: expected %0d, got %0d",
                           want.pixel_col, o_out_data.pixel_col);
                    errors++;
                end
                if (o_out_data.last_of_frame !== want.last_of_frame) begin
                    $error("last_of_frame: expected %0d, got %0d",
                           want.last_of_frame, o_out_data.last_of_frame);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("tb: done, errors");
        $finish;
    end

    initial begin
        t_in_item    px;
        int unsigned fw;
        int unsigned fh;
        int unsigned n;
        int unsigned nf;
        int unsigned span;
        int unsigned sent;
        bit          fs_first;

        cfg_width  = CFG_WIDTH_W'(WIDTH_RST);
        cfg_height = HEIGHT_RST;
        kern[0]    = KERNEL_TOP_RST;
        kern[1]    = KERNEL_MID_RST;
        kern[2]    = KERNEL_BOT_RST;
        row_at     = 0;
        col_at     = 0;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_WIDTH;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames at 3x3 with the reset kernel
        idle_on = 1'b1;
        write_reg(CFG_WIDTH, (rnd48() << CFG_WIDTH_W) | CFG_W'(MIN_DIM));
        write_reg(CFG_HEIGHT, (rnd48() << ROW_W) | CFG_W'(MIN_DIM));
        foreach (DIR_STEPS[k]) begin
            px.pixel       = DIR_STEPS[k].pixel;
            px.frame_start = DIR_STEPS[k].frame_start;
            push_pixel(px, DIR_STEPS[k].typed, DIR_STEPS[k].want);
        end
        flush_pipe();

        // random phases, counters may carry over a register change
        sent = 0;
        while (sent < RAND_ITEMS) begin
            idle_on = (sent + QUIET_TAIL < RAND_ITEMS) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) != 0) begin
                case ($urandom_range(0, 9))
                    0: fw = $urandom_range(0, MIN_DIM - 1);
                    1: fw = $urandom_range(13, 40);
                    // width above the maximum clamps
                    2: fw = BIG_WIDTH;
                    default: fw = $urandom_range(MIN_DIM, 12);
                endcase
                write_reg(CFG_WIDTH, (rnd48() << CFG_WIDTH_W) | CFG_W'(fw));
            end
            if ($urandom_range(0, 1) != 0) begin
                case ($urandom_range(0, 9))
                    0: fh = $urandom_range(0, MIN_DIM - 1);
                    1: fh = 16'hFFFF;
                    2: fh = $urandom_range(0, 16'hFFFF);
                    default: fh = $urandom_range(MIN_DIM, 8);
                endcase
                write_reg(CFG_HEIGHT, (rnd48() << ROW_W) | CFG_W'(fh));
            end
            if ($urandom_range(0, 2) == 0) write_reg(CFG_K_TOP, kernel_row_mix());
            if ($urandom_range(0, 2) == 0) write_reg(CFG_K_MID, kernel_row_mix());
            if ($urandom_range(0, 2) == 0) write_reg(CFG_K_BOT, kernel_row_mix());
            span = eff_cols() * eff_rows();
            if (span > FRAME_CAP) span = FRAME_CAP;
            nf = $urandom_range(1, 3);
            for (int f = 0; f < nf && sent < RAND_ITEMS; f++) begin
                fs_first = ($urandom_range(0, 3) != 0);
                // some frames are cut short or run on from where the counters stand
                n = (fs_first && $urandom_range(0, 5) != 0) ? span : $urandom_range(1, span);
                for (int k = 0; k < n && sent < RAND_ITEMS; k++) begin
                    px.pixel       = PIX_W'($urandom);
                    px.frame_start = fs_first && (k == 0);
                    push_pixel(px, 1'b0, '0);
                    sent++;
                end
            end
            flush_pipe();
        end

        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/c3f_pkg.sv
rtl/core/c3f_ram.sv
rtl/core/c3f_front.sv
rtl/core/c3f_mac.sv
rtl/core/conv3x3_image_filter.sv
rtl/core/c3f_checker.sv
tb/tb.sv
